### sv/nvir_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the night-vision IR controller.
// No dependencies; every other file refers to it by scoped names.
package nvir_pkg;

	// Fixed field widths
	localparam int AVG_W     = 25;
	localparam int SMP_W     = 16;
	localparam int LVL_W     = 7;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int OP_W      = 3;
	localparam int ADJ_W     = 2;
	localparam int MODE_W    = 2;
	localparam int RAW_W     = 32;
	localparam int DRV_W     = 11;

	// Operation codes
	localparam logic [OP_W-1:0] OP_SAMPLE = 3'd0;
	localparam logic [OP_W-1:0] OP_TICK   = 3'd1;
	localparam logic [OP_W-1:0] OP_ADJUST = 3'd2;
	localparam logic [OP_W-1:0] OP_START  = 3'd3;
	localparam logic [OP_W-1:0] OP_STOP   = 3'd4;
	localparam logic [OP_W-1:0] OP_APPLY  = 3'd5;

	// Night modes
	localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ON   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_AUTO = 2'd2;

	// Adjust commands
	localparam logic [ADJ_W-1:0] ADJ_DIM     = 2'd0;
	localparam logic [ADJ_W-1:0] ADJ_RESTORE = 2'd1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ON_THRESH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_SAMP  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DAY_SAMP    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_MIN   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_DAY_MIN     = 3'd7;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic div_start;
		logic div_sel;   // 0: average, 1: scaled sample
		logic exec;
	} nvir_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_div;
		logic div_done;
	} nvir_sts_t;

	// floor(x / 10) for any 11-bit x (0 to 2047), by reciprocal multiply
	function automatic logic [7:0] div10(input logic [DRV_W-1:0] x);
		logic [23:0] p;
		p = 24'(x) * 24'd6554;
		return p[23:16];
	endfunction

endpackage

### sv/nvir_div.sv
`timescale 1ns / 1ps
// Restoring serial divider: one quotient bit per cycle.
// Uses nvir_pkg for widths.
module nvir_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [nvir_pkg::AVG_W-1:0] dividend,
	input  logic [nvir_pkg::SMP_W-1:0] divisor,
	output logic                       done,
	output logic [nvir_pkg::AVG_W-1:0] quotient
);

	localparam int CNT_W = $clog2(nvir_pkg::AVG_W);

	logic                       busy_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [nvir_pkg::SMP_W-1:0] rem_q;
	logic [nvir_pkg::SMP_W-1:0] dvs_q;
	logic [nvir_pkg::AVG_W-1:0] quo_q;
	logic [nvir_pkg::SMP_W:0]   shifted;
	logic [nvir_pkg::SMP_W:0]   diff;
	logic                       fits;

	assign shifted = {rem_q, quo_q[nvir_pkg::AVG_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign fits    = ~diff[nvir_pkg::SMP_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(nvir_pkg::AVG_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[nvir_pkg::SMP_W-1:0] : shifted[nvir_pkg::SMP_W-1:0];
			quo_q <= {quo_q[nvir_pkg::AVG_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### sv/nvir_dp.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, controller state, light average,
// decision logic and result registers. Uses nvir_pkg and nvir_div.
module nvir_dp #(
	parameter int MAX_LEVEL = 99,
	parameter int FRAC_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  nvir_pkg::nvir_cmd_t            cmd,
	output nvir_pkg::nvir_sts_t            sts,
	input  logic                           cfg_wr_en,
	input  logic [nvir_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nvir_pkg::CFG_W-1:0]     cfg_data,
	input  logic [nvir_pkg::OP_W-1:0]      op,
	input  logic [nvir_pkg::RAW_W-1:0]     raw_light,
	input  logic [nvir_pkg::ADJ_W-1:0]     adjust_cmd,
	output logic                           ir_active,
	output logic                           grey_mode,
	output logic [nvir_pkg::LVL_W-1:0]     led_level,
	output logic                           led_write,
	output logic                           accepted
);

	localparam int AW = nvir_pkg::AVG_W;
	localparam int SW = nvir_pkg::SMP_W;
	localparam int LW = nvir_pkg::LVL_W;
	localparam int DW = nvir_pkg::DRV_W;
	localparam logic [LW-1:0] MAX_LVL = LW'(MAX_LEVEL);
	localparam logic [DW-1:0] MAX_DRV = DW'(MAX_LEVEL);

	// Configuration
	logic [nvir_pkg::MODE_W-1:0] mode_q;
	logic [SW-1:0] on_th_q, center_q, band_q;
	logic [SW-1:0] night_samp_q, day_samp_q, night_min_q, day_min_q;

	// Controller state
	logic          ir_q, grey_q, savo_q, adj_q, run_q, tick_q;
	logic [LW-1:0] lvl_q, sav_q;
	logic [SW-1:0] settle_q, smp_q;
	logic [AW-1:0] avg_q;

	// Captured item and quotients
	logic [nvir_pkg::OP_W-1:0]  op_q;
	logic [SW-1:0]              raw_q;
	logic [nvir_pkg::ADJ_W-1:0] adj_cmd_q;
	logic [AW-1:0]              qa_q, qs_q;

	// Divider
	logic [AW-1:0] div_dividend, div_quo;
	logic [SW-1:0] div_divisor, samp_sel;
	logic          div_done;

	// Next state
	logic          ir_n, grey_n, savo_n, adj_n, run_n, tick_n, wrote, acc;
	logic [LW-1:0] lvl_n, sav_n;
	logic [SW-1:0] settle_n, smp_n, settle_inc;
	logic [AW-1:0] avg_n, avg_upd;
	logic          do_drive, do_engage, do_release, do_start, do_off, decide;
	logic [DW-1:0] drv_val, dim_val, grow_val, shrink_val;
	logic [AW:0]   lo_lim, hi_lim, on_lim;
	logic          lo_hit, hi_hit, on_hit;

	assign samp_sel     = ir_q ? night_samp_q : day_samp_q;
	assign div_divisor  = (samp_sel == '0) ? SW'(1) : samp_sel;
	assign div_dividend = cmd.div_sel ? (AW'(smp_q) << FRAC_BITS) : avg_q;

	nvir_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign sts.div_done = div_done;
	assign sts.need_div = tick_q & (ir_q | (smp_q != '0));

	always_comb begin
		settle_inc = (settle_q == {SW{1'b1}}) ? settle_q : settle_q + 1'b1;
		avg_upd    = AW'((AW+1)'(avg_q) - (AW+1)'(qa_q) + (AW+1)'(qs_q));
		lo_lim     = (AW+1)'(center_q - band_q) << FRAC_BITS;
		hi_lim     = ((AW+1)'(center_q) + (AW+1)'(band_q)) << FRAC_BITS;
		on_lim     = (AW+1)'(on_th_q) << FRAC_BITS;
		if (lvl_q < LW'(6))
			dim_val = DW'(lvl_q >> 1);
		else
			dim_val = DW'(nvir_pkg::div10(DW'(lvl_q)));
		if (dim_val == '0)
			dim_val = DW'(1);
		if (lvl_q < LW'(10))
			grow_val = DW'(lvl_q) + 1'b1;
		else
			grow_val = DW'(nvir_pkg::div10(DW'(lvl_q) * DW'(11)));
		shrink_val = DW'(nvir_pkg::div10(DW'(lvl_q) * DW'(9)));
	end

	always_comb begin
		ir_n       = ir_q;
		grey_n     = grey_q;
		lvl_n      = lvl_q;
		sav_n      = sav_q;
		savo_n     = savo_q;
		adj_n      = adj_q;
		run_n      = run_q;
		tick_n     = tick_q;
		settle_n   = settle_q;
		avg_n      = avg_q;
		smp_n      = smp_q;
		wrote      = 1'b0;
		acc        = 1'b1;
		do_drive   = 1'b0;
		drv_val    = '0;
		do_engage  = 1'b0;
		do_release = 1'b0;
		do_start   = 1'b0;
		do_off     = 1'b0;
		decide     = 1'b0;

		unique case (op_q)
			nvir_pkg::OP_SAMPLE: smp_n = raw_q;
			nvir_pkg::OP_TICK: begin
				if (tick_q) begin
					if (ir_q) begin
						avg_n    = avg_upd;
						settle_n = settle_inc;
						decide   = settle_inc >= night_min_q;
					end else if (smp_q == '0) begin
						// dark sample: drop the average and decide at once
						avg_n  = '0;
						decide = 1'b1;
					end else begin
						avg_n    = avg_upd;
						settle_n = settle_inc;
						decide   = settle_inc >= day_min_q;
					end
				end
			end
			nvir_pkg::OP_ADJUST: begin
				if (!ir_q) begin
					acc = 1'b0;
				end else begin
					if (!savo_q) begin
						sav_n  = lvl_q;
						savo_n = 1'b1;
					end
					if (adj_cmd_q == nvir_pkg::ADJ_DIM) begin
						if (!adj_q)
							sav_n = lvl_q;
						adj_n    = 1'b1;
						do_drive = 1'b1;
						drv_val  = dim_val;
					end else if (adj_cmd_q == nvir_pkg::ADJ_RESTORE) begin
						adj_n    = 1'b0;
						do_drive = 1'b1;
						drv_val  = DW'(sav_n);
					end else begin
						adj_n    = 1'b0;
						do_drive = 1'b1;
						drv_val  = MAX_DRV;
					end
				end
			end
			nvir_pkg::OP_START: do_start = 1'b1;
			nvir_pkg::OP_STOP: begin
				do_off = 1'b1;
				run_n  = 1'b0;
			end
			nvir_pkg::OP_APPLY: begin
				avg_n    = hi_lim[AW-1:0];
				do_start = run_q;
			end
			default: ;
		endcase

		lo_hit = (center_q >= band_q) && ((AW+1)'(avg_n) < lo_lim);
		hi_hit = (AW+1)'(avg_n) > hi_lim;
		on_hit = (AW+1)'(avg_n) < on_lim;

		if (decide && run_q) begin
			if (mode_q == nvir_pkg::MODE_ON) begin
				do_engage = 1'b1;
				grey_n    = 1'b1;
			end else if (mode_q == nvir_pkg::MODE_AUTO) begin
				if (ir_q) begin
					if (lo_hit && !adj_q) begin
						do_drive = 1'b1;
						drv_val  = grow_val;
					end else if (hi_hit) begin
						if (lvl_q == '0) begin
							do_release = 1'b1;
							grey_n     = 1'b0;
						end else begin
							do_drive = 1'b1;
							drv_val  = shrink_val;
						end
					end
				end else if (on_hit) begin
					do_engage = 1'b1;
					grey_n    = 1'b1;
				end
			end else begin
				do_off = 1'b1;
			end
		end

		if (do_start) begin
			if (mode_q == nvir_pkg::MODE_OFF) begin
				do_off = 1'b1;
			end else begin
				tick_n = 1'b1;
				if (mode_q == nvir_pkg::MODE_ON) begin
					do_engage = 1'b1;
					grey_n    = 1'b1;
				end
			end
			run_n = 1'b1;
		end

		if (do_off) begin
			tick_n     = 1'b0;
			grey_n     = 1'b0;
			do_release = 1'b1;
		end

		if (do_engage && !ir_q) begin
			do_drive = 1'b1;
			drv_val  = MAX_DRV;
			ir_n     = 1'b1;
		end

		// clamp at the cap; skip the write when already at the cap
		if (do_drive) begin
			if (drv_val >= MAX_DRV) begin
				if (lvl_q != MAX_LVL) begin
					lvl_n    = MAX_LVL;
					settle_n = '0;
					wrote    = 1'b1;
				end
			end else begin
				lvl_n    = drv_val[LW-1:0];
				settle_n = '0;
				wrote    = 1'b1;
			end
		end

		if (do_release) begin
			settle_n = '0;
			if (ir_q) begin
				ir_n  = 1'b0;
				lvl_n = '0;
				wrote = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= nvir_pkg::MODE_OFF;
			on_th_q      <= '0;
			center_q     <= '0;
			band_q       <= '0;
			night_samp_q <= SW'(1);
			day_samp_q   <= SW'(1);
			night_min_q  <= '0;
			day_min_q    <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				nvir_pkg::CFG_NIGHT_MODE: mode_q       <= cfg_data[nvir_pkg::MODE_W-1:0];
				nvir_pkg::CFG_ON_THRESH:  on_th_q      <= cfg_data;
				nvir_pkg::CFG_CENTER:     center_q     <= cfg_data;
				nvir_pkg::CFG_BAND:       band_q       <= cfg_data;
				nvir_pkg::CFG_NIGHT_SAMP: night_samp_q <= cfg_data;
				nvir_pkg::CFG_DAY_SAMP:   day_samp_q   <= cfg_data;
				nvir_pkg::CFG_NIGHT_MIN:  night_min_q  <= cfg_data;
				nvir_pkg::CFG_DAY_MIN:    day_min_q    <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ir_q     <= 1'b0;
			grey_q   <= 1'b0;
			lvl_q    <= '0;
			sav_q    <= '0;
			savo_q   <= 1'b0;
			adj_q    <= 1'b0;
			run_q    <= 1'b0;
			tick_q   <= 1'b0;
			settle_q <= '0;
			avg_q    <= '0;
			smp_q    <= '0;
		end else if (cmd.exec) begin
			ir_q     <= ir_n;
			grey_q   <= grey_n;
			lvl_q    <= lvl_n;
			sav_q    <= sav_n;
			savo_q   <= savo_n;
			adj_q    <= adj_n;
			run_q    <= run_n;
			tick_q   <= tick_n;
			settle_q <= settle_n;
			avg_q    <= avg_n;
			smp_q    <= smp_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= op;
			raw_q     <= raw_light[nvir_pkg::RAW_W-1 -: SW];
			adj_cmd_q <= adjust_cmd;
		end
		if (div_done) begin
			if (cmd.div_sel)
				qs_q <= div_quo;
			else
				qa_q <= div_quo;
		end
		if (cmd.exec) begin
			ir_active <= ir_n;
			grey_mode <= grey_n;
			led_level <= lvl_n;
			led_write <= wrote;
			accepted  <= acc;
		end
	end

endmodule

### sv/nvir_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences capture, the two divisions and the update step,
// and owns both handshakes. Uses nvir_pkg.
module nvir_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [nvir_pkg::OP_W-1:0] op,
	input  logic                      out_stall,
	input  nvir_pkg::nvir_sts_t       sts,
	output nvir_pkg::nvir_cmd_t       cmd,
	output logic                      in_stall,
	output logic                      out_valid
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV_A,
		S_DIV_S,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   div_start_q;
	logic   div_sel_q;
	logic   out_valid_q;
	logic   slot_free;
	logic   exec;

	assign slot_free = ~out_valid_q | ~out_stall;
	assign exec      = (state_q == S_EXEC) & slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_start_q <= 1'b0;
			div_sel_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (exec)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (op == nvir_pkg::OP_TICK && sts.need_div) begin
							state_q     <= S_DIV_A;
							div_start_q <= 1'b1;
							div_sel_q   <= 1'b0;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_DIV_A: begin
					if (sts.div_done) begin
						state_q     <= S_DIV_S;
						div_start_q <= 1'b1;
						div_sel_q   <= 1'b1;
					end
				end
				S_DIV_S: begin
					if (sts.div_done)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd.capture   = (state_q == S_IDLE) & in_valid;
	assign cmd.div_start = div_start_q;
	assign cmd.div_sel   = div_sel_q;
	assign cmd.exec      = exec;
	assign in_stall      = (state_q != S_IDLE);
	assign out_valid     = out_valid_q;

endmodule

### sv/night_vision_ir_controller.sv
`timescale 1ns / 1ps
// Night-vision IR controller, top level. One item in flight at a time.
// A tick that folds a sample into the light average runs two 25-step
// divisions on one serial divider; every other item skips the divider.
// Asynchronous active-low reset clears the control and datapath state
// (not the captured item, divider registers, quotients or result fields),
// loads register defaults and clears out_valid. Uses nvir_pkg, nvir_ctrl and nvir_dp.
module night_vision_ir_controller #(
	parameter int MAX_LEVEL = 99,
	parameter int FRAC_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [nvir_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nvir_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [nvir_pkg::OP_W-1:0]      op,
	input  logic [nvir_pkg::RAW_W-1:0]     raw_light,
	input  logic [nvir_pkg::ADJ_W-1:0]     adjust_cmd,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           ir_active,
	output logic                           grey_mode,
	output logic [nvir_pkg::LVL_W-1:0]     led_level,
	output logic                           led_write,
	output logic                           accepted
);

	nvir_pkg::nvir_cmd_t cmd;
	nvir_pkg::nvir_sts_t sts;

	nvir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	nvir_dp #(
		.MAX_LEVEL (MAX_LEVEL),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.op         (op),
		.raw_light  (raw_light),
		.adjust_cmd (adjust_cmd),
		.ir_active  (ir_active),
		.grey_mode  (grey_mode),
		.led_level  (led_level),
		.led_write  (led_write),
		.accepted   (accepted)
	);

endmodule

### sv/nvir_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the night-vision IR controller and its bind.
// Depends on nvir_pkg and night_vision_ir_controller.
module nvir_chk #(
	parameter int MAX_LEVEL = 99
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       ir_active,
	input logic                       grey_mode,
	input logic [nvir_pkg::LVL_W-1:0] led_level,
	input logic                       led_write,
	input logic                       accepted
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(led_level) && $stable(ir_active)
			&& $stable(grey_mode) && $stable(led_write) && $stable(accepted))
		else $error("stalled result changed");

	// one item at a time: stall right after an accepted beat
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item accepted while busy");

	// grey mode and a lit LED only come with IR engaged; level never passes cap
	a_ir_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ir_active || (!grey_mode && led_level == '0))
			&& (32'(led_level) <= MAX_LEVEL))
		else $error("inconsistent IR state on result");

	// a refused adjust drives nothing
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> !ir_active && !led_write)
		else $error("refused adjust changed the LED");

endmodule

bind night_vision_ir_controller nvir_chk #(
	.MAX_LEVEL (MAX_LEVEL)
) u_nvir_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.ir_active (ir_active),
	.grey_mode (grey_mode),
	.led_level (led_level),
	.led_write (led_write),
	.accepted  (accepted)
);
